// ===== rtl/motor_drive_fault_latch_core_macros.svh =====
// Assertion macros shared by the fault latch RTL.
`ifndef MOTOR_DRIVE_FAULT_LATCH_CORE_MACROS_SVH
`define MOTOR_DRIVE_FAULT_LATCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge, ignored while reset is asserted.
`define MDFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MDFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MDFL_ASSERT(lbl, prop, msg)
`define MDFL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/mdfl_pkg.sv =====
package mdfl_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int OC_TRIP_W   = 15;
  localparam int VBUS_W      = 16;
  localparam int MASK_W      = 7;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // Compare width that holds a sample, a trip level and its negation.
  localparam int CMP_W = ((SAMPLE_BITS > OC_TRIP_W) ? SAMPLE_BITS : OC_TRIP_W) + 2;

  // Register reset values.
  localparam logic [OC_TRIP_W-1:0] OC_TRIP_RST = '1;
  localparam logic [VBUS_W-1:0]    OV_TRIP_RST = '1;
  localparam logic [VBUS_W-1:0]    UV_TRIP_RST = '0;

  // Fault mask bits.
  localparam logic [MASK_W-1:0] FAULT_OC     = 7'h01;
  localparam logic [MASK_W-1:0] FAULT_OV     = 7'h02;
  localparam logic [MASK_W-1:0] FAULT_UV     = 7'h04;
  localparam logic [MASK_W-1:0] FAULT_GATE   = 7'h10;
  localparam logic [MASK_W-1:0] FAULT_SENSOR = 7'h20;
  localparam int                FAULT_OC_BIT = 0;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LATCH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_U    = 2'd1,
    PH_V    = 2'd2,
    PH_W    = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OC_TRIP = 2'd0,
    CFG_OV_TRIP = 2'd1,
    CFG_UV_TRIP = 2'd2
  } cfg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [CMP_W-1:0]       cmp_t;

  typedef struct packed {
    logic [OC_TRIP_W-1:0] oc_trip;
    logic [VBUS_W-1:0]    ov_trip;
    logic [VBUS_W-1:0]    uv_trip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    sample_t           current_u;
    sample_t           current_v;
    sample_t           current_w;
    logic [VBUS_W-1:0] bus_voltage;
    logic              driving;
    logic              running;
    logic              gate_fault;
    logic              sensor_lost;
    logic [MASK_W-1:0] external_bits;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0] latched;
    sample_t           snap_u;
    sample_t           snap_v;
    sample_t           snap_w;
    phase_e            snap_phase;
  } fstate_t;

endpackage

// ===== rtl/mdfl_in_if.sv =====
// Input channel: one control tick per transaction.
interface mdfl_in_if import mdfl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  sample_t           current_u;
  sample_t           current_v;
  sample_t           current_w;
  logic [VBUS_W-1:0] bus_voltage;
  logic              driving;
  logic              running;
  logic              gate_fault;
  logic              sensor_lost;
  logic [MASK_W-1:0] external_bits;

  modport source (
    output valid, opcode, current_u, current_v, current_w, bus_voltage,
           driving, running, gate_fault, sensor_lost, external_bits,
    input  ready
  );

  modport sink (
    input  valid, opcode, current_u, current_v, current_w, bus_voltage,
           driving, running, gate_fault, sensor_lost, external_bits,
    output ready
  );
endinterface

// ===== rtl/mdfl_out_if.sv =====
// Result channel: fault status after each tick.
interface mdfl_out_if import mdfl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fault_mask;
  logic              raise_fault;
  logic [1:0]        trip_phase;
  sample_t           trip_current_u;
  sample_t           trip_current_v;
  sample_t           trip_current_w;

  modport source (
    output valid, fault_mask, raise_fault, trip_phase,
           trip_current_u, trip_current_v, trip_current_w,
    input  ready
  );

  modport sink (
    input  valid, fault_mask, raise_fault, trip_phase,
           trip_current_u, trip_current_v, trip_current_w,
    output ready
  );
endinterface

// ===== rtl/mdfl_cfg_regs.sv =====
module mdfl_cfg_regs import mdfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode the write; an index past the register list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OC_TRIP: cfg_d.oc_trip = cfg_wdata_i[OC_TRIP_W-1:0];
        CFG_OV_TRIP: cfg_d.ov_trip = cfg_wdata_i[VBUS_W-1:0];
        CFG_UV_TRIP: cfg_d.uv_trip = cfg_wdata_i[VBUS_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oc_trip <= OC_TRIP_RST;
      cfg_q.ov_trip <= OV_TRIP_RST;
      cfg_q.uv_trip <= UV_TRIP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/mdfl_eval.sv =====
module mdfl_eval import mdfl_pkg::*; (
  input  item_t   item_i,
  input  fstate_t state_i,
  input  cfg_t    cfg_i,
  output fstate_t state_o,
  output logic    raise_o
);

  // True when the current lies outside the symmetric trip window.
  function automatic logic breach(input sample_t cur, input cmp_t trip);
    cmp_t cur_x;
    cur_x = cmp_t'(cur);
    return (cur_x > trip) || (cur_x < -trip);
  endfunction

  cmp_t              trip_pos;
  logic              br_u, br_v, br_w;
  phase_e            phase;
  logic [MASK_W-1:0] check_bits;
  logic [MASK_W-1:0] merged;

  assign trip_pos = cmp_t'(cfg_i.oc_trip);
  assign br_u     = breach(item_i.current_u, trip_pos);
  assign br_v     = breach(item_i.current_v, trip_pos);
  assign br_w     = breach(item_i.current_w, trip_pos);

  // First breaching phase in U, V, W priority; none while not driving.
  always_comb begin
    if (!item_i.driving) begin
      phase = PH_NONE;
    end else if (br_u) begin
      phase = PH_U;
    end else if (br_v) begin
      phase = PH_V;
    end else if (br_w) begin
      phase = PH_W;
    end else begin
      phase = PH_NONE;
    end
  end

  // Conditions found by a check tick.
  always_comb begin
    check_bits = '0;
    if (phase != PH_NONE) check_bits |= FAULT_OC;
    if (item_i.bus_voltage > cfg_i.ov_trip) check_bits |= FAULT_OV;
    if (item_i.running && (item_i.bus_voltage < cfg_i.uv_trip)) check_bits |= FAULT_UV;
    if (item_i.gate_fault) check_bits |= FAULT_GATE;
    if (item_i.driving && item_i.sensor_lost) check_bits |= FAULT_SENSOR;
  end

  assign merged = state_i.latched | check_bits;

  // Next state and raise flag per opcode.
  always_comb begin
    state_o = state_i;
    raise_o = 1'b0;
    case (item_i.opcode)
      OP_CHECK: begin
        state_o.latched = merged;
        raise_o         = (merged != '0);
        // Snapshot only on the first overcurrent latch.
        if ((phase != PH_NONE) && !state_i.latched[FAULT_OC_BIT]) begin
          state_o.snap_u     = item_i.current_u;
          state_o.snap_v     = item_i.current_v;
          state_o.snap_w     = item_i.current_w;
          state_o.snap_phase = phase;
        end
      end
      OP_CLEAR: state_o.latched = '0;
      OP_LATCH: state_o.latched = state_i.latched | item_i.external_bits;
      default:  state_o = state_i;
    endcase
  end

endmodule

// ===== rtl/motor_drive_fault_latch_core.sv =====
// Motor drive fault latch. Each input transaction is one control tick: a
// check, a clear of the latched mask, or an OR of external fault bits. The
// block accepts one transaction per clock cycle unless the result side stalls,
// and returns exactly one result per transaction, held first in the input
// register and then in the result register. Throughput is one per cycle,
// bounded by the single evaluation stage that reads and updates the latched
// fault state between those two registers. Latched bits stay set until a clear
// tick; the overcurrent snapshot is taken only when the overcurrent bit goes
// from clear to set through a check. The user must write trip registers through the
// configuration port only while no transaction is in flight; the block does not enforce it.
`include "motor_drive_fault_latch_core_macros.svh"

module motor_drive_fault_latch_core import mdfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mdfl_in_if.sink               item_i,
  mdfl_out_if.source            result_o
);

  cfg_t    cfg;
  item_t   in_d, in_q;
  logic    in_valid_d, in_valid_q;
  logic    out_valid_d, out_valid_q;
  logic    in_accept;
  logic    advance;
  fstate_t state_d, state_q;
  logic    raise;
  logic    raise_d, raise_q;
  fstate_t res_d, res_q;

  mdfl_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input register moves on when the result register is free.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_accept    = item_i.valid && item_i.ready;

  always_comb begin
    in_d.opcode        = item_i.opcode;
    in_d.current_u     = item_i.current_u;
    in_d.current_v     = item_i.current_v;
    in_d.current_w     = item_i.current_w;
    in_d.bus_voltage   = item_i.bus_voltage;
    in_d.driving       = item_i.driving;
    in_d.running       = item_i.running;
    in_d.gate_fault    = item_i.gate_fault;
    in_d.sensor_lost   = item_i.sensor_lost;
    in_d.external_bits = item_i.external_bits;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  mdfl_eval u_eval (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .raise_o (raise)
  );

  assign res_d   = advance ? state_d : res_q;
  assign raise_d = advance ? raise : raise_q;

  // Control and fault state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_d;
    end
    res_q   <= res_d;
    raise_q <= raise_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.fault_mask     = res_q.latched;
  assign result_o.raise_fault    = raise_q;
  assign result_o.trip_phase     = res_q.snap_phase;
  assign result_o.trip_current_u = res_q.snap_u;
  assign result_o.trip_current_v = res_q.snap_v;
  assign result_o.trip_current_w = res_q.snap_w;

  // A held input must not be overwritten while the result side stalls.
  `MDFL_ASSERT(a_no_overrun, (in_valid_q && out_valid_q && !result_o.ready) |-> !item_i.ready, "input accepted while pipeline is blocked")
  // The snapshot may change only when the overcurrent bit was clear before.
  `MDFL_ASSERT(a_snap_sticky, (state_q.latched[FAULT_OC_BIT] && $past(state_q.latched[FAULT_OC_BIT])) |-> $stable(state_q.snap_phase), "overcurrent snapshot recaptured")
  // A raised fault always comes with a nonzero mask.
  `MDFL_ASSERT(a_raise_mask, (result_o.valid && result_o.raise_fault) |-> (result_o.fault_mask != '0), "raise without latched fault")
  // No result is shown while reset holds the pipeline empty.
  `MDFL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!result_o.valid && item_i.ready), "pipeline not empty during reset")

endmodule
